[rtl/core/sepq_pkg.sv]
// Shared types and constants for the stable priority event queue.
// Used by sepq_ctrl, sepq_datapath and stable_priority_event_queue; no dependencies.
package sepq_pkg;

	localparam int QueueDepth = 16;
	localparam int IdxW       = $clog2(QueueDepth);
	localparam int CntW       = $clog2(QueueDepth + 1);
	localparam int IdW        = 8;
	localparam int PrioW      = 8;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_EXEC = 2'd1,
		OP_DEL  = 2'd2,
		OP_CLR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_HALTED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_APPLY
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic calc;
		logic apply;
	} cmd_t;

endpackage

[rtl/core/stable_priority_event_queue.sv]
// Stable priority event queue: sorted by priority, equal priorities in arrival order.
// A request goes through capture, parallel compare and shift/compact; the result is
// registered at the update step. No new request is taken until that step is done.
// The update step waits while the previous result is still stalled at the output.
// Reset: queue empty, run_enable set to 1; slot contents are left unset.
// Depends on sepq_pkg, sepq_ctrl and sepq_datapath.
module stable_priority_event_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 op,
	input  logic [sepq_pkg::IdW-1:0]   event_id,
	input  logic [sepq_pkg::PrioW-1:0] priority_req,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic                       dispatch_valid,
	output logic [sepq_pkg::IdW-1:0]   dispatch_id,
	output logic [sepq_pkg::CntW-1:0]  event_count
);
	import sepq_pkg::*;

	cmd_t cmd;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	sepq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sepq_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.op             (op),
		.event_id       (event_id),
		.priority_req   (priority_req),
		.status         (status),
		.dispatch_valid (dispatch_valid),
		.dispatch_id    (dispatch_id),
		.event_count    (event_count)
	);

endmodule

[rtl/core/sepq_ctrl.sv]
// Controller state machine: sequences capture, compare and update of one request.
// Depends on sepq_pkg; drives the command struct for sepq_datapath.
module sepq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output sepq_pkg::cmd_t  cmd
);
	import sepq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_valid_d;
	logic   apply_go;

	// State register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		apply_go    = !out_valid_q || !out_stall;
		out_valid_d = out_valid_q && out_stall;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_APPLY;
			end
			S_APPLY: begin
				// hold until the output register is free
				if (apply_go) begin
					cmd.apply   = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_CALC))
		else $error("accepted request did not enter compare step");
	a_calc_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC) |=> (state_q == S_APPLY))
		else $error("compare step not followed by update step");
	a_hold_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && out_valid_q && out_stall) |=> (state_q == S_APPLY))
		else $error("update step left while output blocked");
	a_rose_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_APPLY))
		else $error("result raised outside update step");
`endif

endmodule

[rtl/core/sepq_datapath.sv]
// Datapath: slot registers, parallel compare, insert shift and compaction, result register.
// Depends on sepq_pkg; driven by commands from sepq_ctrl.
module sepq_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sepq_pkg::cmd_t             cmd,
	input  logic                       cfg_we,
	input  logic                       cfg_data,
	input  logic [1:0]                 op,
	input  logic [sepq_pkg::IdW-1:0]   event_id,
	input  logic [sepq_pkg::PrioW-1:0] priority_req,
	output logic [1:0]                 status,
	output logic                       dispatch_valid,
	output logic [sepq_pkg::IdW-1:0]   dispatch_id,
	output logic [sepq_pkg::CntW-1:0]  event_count
);
	import sepq_pkg::*;

	logic [IdW-1:0]   ids_q   [QueueDepth];
	logic [PrioW-1:0] prios_q [QueueDepth];
	logic [CntW-1:0]  count_q;
	logic             run_en_q;

	op_t              op_q;
	logic [IdW-1:0]   id_q;
	logic [PrioW-1:0] prio_q;

	logic [QueueDepth-1:0] keep_q;
	logic [QueueDepth-1:0] ins_q;
	logic [IdxW-1:0]       dest_q [QueueDepth];
	logic [QueueDepth-1:0] keep_c;
	logic [QueueDepth-1:0] ins_c;
	logic [IdxW-1:0]       dest_c [QueueDepth];
	logic [IdW-1:0]        pid;

	logic [IdW-1:0]   cmp_ids   [QueueDepth];
	logic [PrioW-1:0] cmp_prios [QueueDepth];
	logic [IdW-1:0]   add_ids   [QueueDepth];
	logic [PrioW-1:0] add_prios [QueueDepth];
	logic [CntW-1:0]  kept_n;
	logic             wr_add;
	logic             wr_cmp;
	logic [CntW-1:0]  count_d;
	status_t          res_status;
	logic             res_dv;
	logic [IdW-1:0]   res_did;

	status_t          status_q;
	logic             dv_q;
	logic [IdW-1:0]   did_q;
	logic [CntW-1:0]  evc_q;

	// Control registers: count and run enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			run_en_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				run_en_q <= cfg_data;
			end
			if (cmd.apply) begin
				count_q <= count_d;
			end
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(op);
			id_q   <= event_id;
			prio_q <= priority_req;
		end
	end

	// Compare every slot against the request
	always_comb begin
		pid = (op_q == OP_EXEC) ? ids_q[0] : id_q;
		for (int k = 0; k < QueueDepth; k++) begin
			keep_c[k] = (CntW'(k) < count_q) && (ids_q[k] != pid);
			ins_c[k]  = !(CntW'(k) < count_q) || (prio_q < prios_q[k]);
		end
		for (int k = 0; k < QueueDepth; k++) begin
			dest_c[k] = IdxW'($countones(keep_c &
				((QueueDepth'(1) << k) - QueueDepth'(1))));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			keep_q <= keep_c;
			ins_q  <= ins_c;
			dest_q <= dest_c;
		end
	end

	// Build the compacted and the inserted slot images
	always_comb begin
		kept_n = CntW'($countones(keep_q));
		for (int w = 0; w < QueueDepth; w++) begin
			cmp_ids[w]   = '0;
			cmp_prios[w] = '0;
			for (int r = 0; r < QueueDepth; r++) begin
				if (keep_q[r] && (dest_q[r] == IdxW'(w))) begin
					cmp_ids[w]   = cmp_ids[w] | ids_q[r];
					cmp_prios[w] = cmp_prios[w] | prios_q[r];
				end
			end
		end
		add_ids[0]   = ins_q[0] ? id_q : ids_q[0];
		add_prios[0] = ins_q[0] ? prio_q : prios_q[0];
		for (int k = 1; k < QueueDepth; k++) begin
			if (ins_q[k] && !ins_q[k-1]) begin
				add_ids[k]   = id_q;
				add_prios[k] = prio_q;
			end else if (ins_q[k]) begin
				add_ids[k]   = ids_q[k-1];
				add_prios[k] = prios_q[k-1];
			end else begin
				add_ids[k]   = ids_q[k];
				add_prios[k] = prios_q[k];
			end
		end
	end

	// Decide the outcome of the request
	always_comb begin
		res_status = STAT_OK;
		res_dv     = 1'b0;
		res_did    = '0;
		wr_add     = 1'b0;
		wr_cmp     = 1'b0;
		count_d    = count_q;
		case (op_q)
			OP_ADD: begin
				if (count_q == CntW'(QueueDepth)) begin
					res_status = STAT_FULL;
				end else begin
					wr_add  = 1'b1;
					count_d = count_q + CntW'(1);
				end
			end
			OP_EXEC: begin
				if (!run_en_q) begin
					res_status = STAT_HALTED;
				end else if (count_q == '0) begin
					res_status = STAT_EMPTY;
				end else begin
					res_dv  = 1'b1;
					res_did = ids_q[0];
					wr_cmp  = 1'b1;
					count_d = kept_n;
				end
			end
			OP_DEL: begin
				if (count_q == '0) begin
					res_status = STAT_EMPTY;
				end else begin
					wr_cmp  = 1'b1;
					count_d = kept_n;
				end
			end
			OP_CLR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// Update slots and load the result register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (wr_add) begin
				ids_q   <= add_ids;
				prios_q <= add_prios;
			end else if (wr_cmp) begin
				ids_q   <= cmp_ids;
				prios_q <= cmp_prios;
			end
			status_q <= res_status;
			dv_q     <= res_dv;
			did_q    <= res_did;
			evc_q    <= count_d;
		end
	end

	assign status         = status_q;
	assign dispatch_valid = dv_q;
	assign dispatch_id    = did_q;
	assign event_count    = evc_q;

endmodule
